### rtl/bridge_tree_connectivity_assert.svh
// Assertion macros shared by the bridge tree connectivity RTL
`ifndef BRIDGE_TREE_CONNECTIVITY_ASSERT_SVH
`define BRIDGE_TREE_CONNECTIVITY_ASSERT_SVH

// same-cycle implication
`define BTC_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("btc: assertion failed");

// next-cycle implication
`define BTC_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("btc: assertion failed");

`endif

### rtl/btc_pkg.sv
// Shared constants, types and controller/datapath interface for bridge tree connectivity
package btc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 4096;
	localparam int VC_RESET     = 1024;

	localparam int FW   = 11;                   // input field width
	localparam int VW   = $clog2(MAX_VERTICES); // vertex index
	localparam int CW   = VW + 1;               // vertex count / depth
	localparam int CMPW = (FW > CW) ? FW : CW;
	localparam int EW   = $clog2(MAX_EDGES);    // edge index
	localparam int TW   = EW + 1;               // edge total
	localparam int KW   = EW + 2;               // edge-side cursor
	localparam int DW   = 11;                   // discovery / low numbers
	localparam int RW   = 4;                    // rank
	localparam int SW   = VW + KW;              // stack entry

	typedef logic [FW-1:0]   field_t;
	typedef logic [VW-1:0]   vtx_t;
	typedef logic [CW-1:0]   cnt_t;
	typedef logic [CMPW-1:0] cmp_t;
	typedef logic [EW-1:0]   eidx_t;
	typedef logic [TW-1:0]   tot_t;
	typedef logic [KW-1:0]   cur_t;
	typedef logic [DW-1:0]   num_t;
	typedef logic [RW-1:0]   rank_t;
	typedef logic [SW-1:0]   sent_t;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_NEW     = 2'd0;
	localparam mode_t MODE_ADD     = 2'd1;
	localparam mode_t MODE_ANALYZE = 2'd2;
	localparam mode_t MODE_QUERY   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

	typedef enum logic [4:0] {
		OP_IDLE, OP_ACCEPT, OP_CLEAR, OP_ROOT, OP_RTEST, OP_STEP, OP_EDGE, OP_NB,
		OP_POP, OP_POPW, OP_POPJ, OP_FRD, OP_FCMP, OP_FEND, OP_RK1, OP_RK2, OP_RK3,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic query;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic clr_last;
		logic root_end;
		logic root_visited;
		logic cursor_end;
		logic edge_hit;
		logic depth_one;
		logic join_need;
		logic find_hit;
		logic find_phase;
		logic roots_equal;
	} stat_t;

endpackage

### rtl/bridge_tree_connectivity.sv
// Top level of the bridge tree connectivity block
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+---------------------------------
//  item in   | start, busy (taken: start & !busy) | mode, first_vertex, second_vertex
//  result    | done (one-cycle strobe)            | status, joined_by_bridges
//  config    | vertex_count_we                    | vertex_count
//
// Edge load: done strobes in the cycle after acceptance.
// Begin-graph and analyze first run a clearing pass over every entry of the
// visited, leader and rank memories; begin-graph then strobes done.
// Analyze: a root check per vertex, a scan of both edge sides of the whole store for each visited
// vertex plus a neighbour step per neighbour found, a pop per finished vertex, and per join
// leader reads on the single leader port followed by the link.
// Query: leader reads on each vertex, then the compare and the done strobe.
// After reset the block is busy while the sets are cleared.
// Results cannot be held off; one beat is in flight at a time.
module bridge_tree_connectivity (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  btc_pkg::mode_t   mode,
	input  btc_pkg::field_t  first_vertex,
	input  btc_pkg::field_t  second_vertex,
	input  logic             vertex_count_we,
	input  btc_pkg::field_t  vertex_count,
	output logic             done,
	output btc_pkg::status_t status,
	output logic             joined_by_bridges
);

	btc_pkg::cmd_t  cmd;
	btc_pkg::stat_t stat;

	btc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	btc_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.mode              (mode),
		.first_vertex      (first_vertex),
		.second_vertex     (second_vertex),
		.vertex_count_we   (vertex_count_we),
		.vertex_count      (vertex_count),
		.status            (status),
		.joined_by_bridges (joined_by_bridges)
	);

endmodule

### rtl/btc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port
module btc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/btc_datapath.sv
// Datapath: edge store, walk memories, explicit stack and union-find
`include "bridge_tree_connectivity_assert.svh"
module btc_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  btc_pkg::cmd_t    cmd,
	output btc_pkg::stat_t   stat,
	input  btc_pkg::mode_t   mode,
	input  btc_pkg::field_t  first_vertex,
	input  btc_pkg::field_t  second_vertex,
	input  logic             vertex_count_we,
	input  btc_pkg::field_t  vertex_count,
	output btc_pkg::status_t status,
	output logic             joined_by_bridges
);

	localparam btc_pkg::cur_t C_ONE = btc_pkg::cur_t'(1);
	localparam btc_pkg::cnt_t D_ONE = btc_pkg::cnt_t'(1);

	btc_pkg::field_t  vc_q;
	btc_pkg::tot_t    total_q;
	btc_pkg::vtx_t    clr_q;
	btc_pkg::cnt_t    root_q;
	btc_pkg::cnt_t    depth_q;
	btc_pkg::vtx_t    top_u_q, nb_q, cu_q, cur_q, fb_q, rx_q, ry_q;
	btc_pkg::cur_t    top_c_q;
	logic             side_q, phase_q, joined_q;
	btc_pkg::num_t    cnt_q, lu_q;
	btc_pkg::rank_t   rkx_q;
	btc_pkg::status_t status_q;

	btc_pkg::cmp_t  nv, x_ext, y_ext;
	btc_pkg::vtx_t  xa, ya, nb_w, visit_v, visit_from, stk_v;
	btc_pkg::cur_t  stk_c;
	btc_pkg::cnt_t  depth_m1, depth_m2;
	logic           in_range, full, add_ok, visit, push, low_nb, edge_ok, edge_match;
	logic           rk_eq, rk_gt;
	btc_pkg::rank_t rk_new;

	btc_pkg::vtx_t  ea_rd, eb_rd, par_rd, ldr_rd;
	btc_pkg::num_t  disc_rd, low_rd;
	logic           vis_rd;
	btc_pkg::sent_t stk_rd;
	btc_pkg::rank_t rank_rd;

	logic           low_we, ldr_we, rank_we;
	btc_pkg::vtx_t  low_raddr, low_waddr, disc_raddr, vis_raddr, vis_waddr;
	btc_pkg::vtx_t  ldr_waddr, ldr_wdata, rank_waddr, rank_raddr;
	btc_pkg::num_t  low_wdata;
	btc_pkg::rank_t rank_wdata;

	// input decode
	assign nv = (btc_pkg::cmp_t'(vc_q) > btc_pkg::cmp_t'(btc_pkg::MAX_VERTICES)) ?
		btc_pkg::cmp_t'(btc_pkg::MAX_VERTICES) : btc_pkg::cmp_t'(vc_q);
	assign x_ext = btc_pkg::cmp_t'(first_vertex);
	assign y_ext = btc_pkg::cmp_t'(second_vertex);
	assign in_range = (x_ext != '0) && (x_ext <= nv) && (y_ext != '0) && (y_ext <= nv);
	assign xa = btc_pkg::vtx_t'(first_vertex - btc_pkg::field_t'(1));
	assign ya = btc_pkg::vtx_t'(second_vertex - btc_pkg::field_t'(1));
	assign full = total_q >= btc_pkg::tot_t'(btc_pkg::MAX_EDGES);
	assign add_ok = (cmd.op == btc_pkg::OP_ACCEPT) && (mode == btc_pkg::MODE_ADD) &&
		in_range && !full;

	// edge inspection
	assign edge_ok = (btc_pkg::cmp_t'(ea_rd) < nv) && (btc_pkg::cmp_t'(eb_rd) < nv);
	assign edge_match = side_q ? (eb_rd == top_u_q) : (ea_rd == top_u_q);
	assign nb_w = side_q ? ea_rd : eb_rd;

	// vertex visit
	assign push = (cmd.op == btc_pkg::OP_NB) && !vis_rd &&
		(depth_q < btc_pkg::cnt_t'(btc_pkg::MAX_VERTICES));
	assign visit = ((cmd.op == btc_pkg::OP_RTEST) && !vis_rd) || push;
	assign visit_v = (cmd.op == btc_pkg::OP_RTEST) ? btc_pkg::vtx_t'(root_q) : nb_q;
	assign visit_from = (cmd.op == btc_pkg::OP_RTEST) ? btc_pkg::vtx_t'(root_q) : top_u_q;
	assign low_nb = (cmd.op == btc_pkg::OP_NB) && vis_rd && (nb_q != par_rd) &&
		(disc_rd < low_rd);
	assign depth_m1 = depth_q - D_ONE;
	assign depth_m2 = depth_q - btc_pkg::cnt_t'(2);
	assign stk_v = stk_rd[btc_pkg::SW-1 -: btc_pkg::VW];
	assign stk_c = stk_rd[btc_pkg::KW-1:0];

	// union by rank
	assign rk_eq = (rkx_q == rank_rd);
	assign rk_new = rk_eq ? rkx_q + btc_pkg::rank_t'(1) : rkx_q;
	assign rk_gt = rk_new > rank_rd;

	assign vis_raddr = (cmd.op == btc_pkg::OP_ROOT) ? btc_pkg::vtx_t'(root_q) : nb_w;
	assign vis_waddr = (cmd.op == btc_pkg::OP_CLEAR) ? clr_q : visit_v;
	assign disc_raddr = (cmd.op == btc_pkg::OP_POPW) ? stk_v : nb_w;
	assign low_raddr = (cmd.op == btc_pkg::OP_POPW) ? stk_v : top_u_q;
	assign low_we = visit || low_nb ||
		((cmd.op == btc_pkg::OP_POPJ) && (lu_q < low_rd));
	assign low_waddr = visit ? visit_v : top_u_q;
	assign low_wdata = visit ? cnt_q : (low_nb ? disc_rd : lu_q);
	assign ldr_we = (cmd.op == btc_pkg::OP_CLEAR) || (cmd.op == btc_pkg::OP_RK3);
	assign ldr_waddr = (cmd.op == btc_pkg::OP_CLEAR) ? clr_q : (rk_gt ? ry_q : rx_q);
	assign ldr_wdata = (cmd.op == btc_pkg::OP_CLEAR) ? clr_q : (rk_gt ? rx_q : ry_q);
	assign rank_we = (cmd.op == btc_pkg::OP_CLEAR) || ((cmd.op == btc_pkg::OP_RK3) && rk_eq);
	assign rank_waddr = (cmd.op == btc_pkg::OP_CLEAR) ? clr_q : rx_q;
	assign rank_wdata = (cmd.op == btc_pkg::OP_CLEAR) ? '0 : rk_new;
	assign rank_raddr = (cmd.op == btc_pkg::OP_RK1) ? rx_q : ry_q;

	btc_ram #(.WIDTH(btc_pkg::VW), .DEPTH(btc_pkg::MAX_EDGES)) u_edge_a (
		.clk(clk), .we(add_ok), .waddr(btc_pkg::eidx_t'(total_q)), .wdata(xa),
		.raddr(top_c_q[btc_pkg::EW:1]), .rdata(ea_rd));
	btc_ram #(.WIDTH(btc_pkg::VW), .DEPTH(btc_pkg::MAX_EDGES)) u_edge_b (
		.clk(clk), .we(add_ok), .waddr(btc_pkg::eidx_t'(total_q)), .wdata(ya),
		.raddr(top_c_q[btc_pkg::EW:1]), .rdata(eb_rd));
	btc_ram #(.WIDTH(1), .DEPTH(btc_pkg::MAX_VERTICES)) u_visited (
		.clk(clk), .we((cmd.op == btc_pkg::OP_CLEAR) || visit), .waddr(vis_waddr),
		.wdata(visit), .raddr(vis_raddr), .rdata(vis_rd));
	btc_ram #(.WIDTH(btc_pkg::DW), .DEPTH(btc_pkg::MAX_VERTICES)) u_disc (
		.clk(clk), .we(visit), .waddr(visit_v), .wdata(cnt_q),
		.raddr(disc_raddr), .rdata(disc_rd));
	btc_ram #(.WIDTH(btc_pkg::DW), .DEPTH(btc_pkg::MAX_VERTICES)) u_low (
		.clk(clk), .we(low_we), .waddr(low_waddr), .wdata(low_wdata),
		.raddr(low_raddr), .rdata(low_rd));
	btc_ram #(.WIDTH(btc_pkg::VW), .DEPTH(btc_pkg::MAX_VERTICES)) u_parent (
		.clk(clk), .we(visit), .waddr(visit_v), .wdata(visit_from),
		.raddr(top_u_q), .rdata(par_rd));
	btc_ram #(.WIDTH(btc_pkg::SW), .DEPTH(btc_pkg::MAX_VERTICES)) u_stack (
		.clk(clk), .we(push), .waddr(btc_pkg::vtx_t'(depth_m1)),
		.wdata({top_u_q, top_c_q}), .raddr(btc_pkg::vtx_t'(depth_m2)), .rdata(stk_rd));
	btc_ram #(.WIDTH(btc_pkg::VW), .DEPTH(btc_pkg::MAX_VERTICES)) u_leader (
		.clk(clk), .we(ldr_we), .waddr(ldr_waddr), .wdata(ldr_wdata),
		.raddr(cur_q), .rdata(ldr_rd));
	btc_ram #(.WIDTH(btc_pkg::RW), .DEPTH(btc_pkg::MAX_VERTICES)) u_rank (
		.clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
		.raddr(rank_raddr), .rdata(rank_rd));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q    <= btc_pkg::field_t'(btc_pkg::VC_RESET);
			total_q <= '0;
			clr_q   <= '0;
		end else begin
			if (vertex_count_we) begin
				vc_q <= vertex_count;
			end
			if (cmd.op == btc_pkg::OP_ACCEPT && mode == btc_pkg::MODE_NEW) begin
				total_q <= '0;
			end else if (add_ok) begin
				total_q <= total_q + btc_pkg::tot_t'(1);
			end
			if (cmd.op == btc_pkg::OP_CLEAR) begin
				clr_q <= clr_q + btc_pkg::vtx_t'(1);
			end
		end
	end

	// walk and find registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			btc_pkg::OP_ACCEPT: begin
				fb_q     <= ya;
				cur_q    <= xa;
				phase_q  <= 1'b0;
				joined_q <= 1'b0;
				root_q   <= '0;
				depth_q  <= '0;
				cnt_q    <= '0;
				if ((mode == btc_pkg::MODE_ADD || mode == btc_pkg::MODE_QUERY) && !in_range) begin
					status_q <= btc_pkg::ST_RANGE;
				end else if (mode == btc_pkg::MODE_ADD && full) begin
					status_q <= btc_pkg::ST_FULL;
				end else begin
					status_q <= btc_pkg::ST_OK;
				end
			end
			btc_pkg::OP_RTEST: begin
				if (vis_rd) begin
					root_q <= root_q + D_ONE;
				end else begin
					top_u_q <= btc_pkg::vtx_t'(root_q);
					top_c_q <= '0;
					depth_q <= D_ONE;
					cnt_q   <= cnt_q + btc_pkg::num_t'(1);
				end
			end
			btc_pkg::OP_STEP: begin
				if (!stat.cursor_end) begin
					top_c_q <= top_c_q + C_ONE;
					side_q  <= top_c_q[0];
				end
			end
			btc_pkg::OP_EDGE: begin
				nb_q <= nb_w;
			end
			btc_pkg::OP_NB: begin
				if (push) begin
					top_u_q <= nb_q;
					top_c_q <= '0;
					depth_q <= depth_q + D_ONE;
					cnt_q   <= cnt_q + btc_pkg::num_t'(1);
				end
			end
			btc_pkg::OP_POP: begin
				depth_q <= depth_m1;
				cu_q    <= top_u_q;
			end
			btc_pkg::OP_POPW: begin
				top_u_q <= stk_v;
				top_c_q <= stk_c;
				lu_q    <= low_rd;
			end
			btc_pkg::OP_POPJ: begin
				fb_q    <= top_u_q;
				cur_q   <= cu_q;
				phase_q <= 1'b0;
			end
			btc_pkg::OP_FCMP: begin
				if (ldr_rd == cur_q) begin
					if (!phase_q) begin
						rx_q    <= cur_q;
						phase_q <= 1'b1;
						cur_q   <= fb_q;
					end else begin
						ry_q <= cur_q;
					end
				end else begin
					cur_q <= ldr_rd;
				end
			end
			btc_pkg::OP_FEND: begin
				if (cmd.query) begin
					joined_q <= (rx_q == ry_q);
				end
			end
			btc_pkg::OP_RK2: begin
				rkx_q <= rank_rd;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.in_range     = in_range;
		stat.clr_last     = &clr_q;
		stat.root_end     = btc_pkg::cmp_t'(root_q) == nv;
		stat.root_visited = vis_rd;
		stat.cursor_end   = top_c_q >= {total_q, 1'b0};
		stat.edge_hit     = edge_ok && edge_match;
		stat.depth_one    = depth_q == D_ONE;
		stat.join_need    = lu_q > disc_rd;
		stat.find_hit     = ldr_rd == cur_q;
		stat.find_phase   = phase_q;
		stat.roots_equal  = rx_q == ry_q;
	end

	assign status = status_q;
	assign joined_by_bridges = joined_q;

	`BTC_ASSERT_NEXT(a_cursor_steps, clk, arst_n, cmd.op == btc_pkg::OP_STEP && !stat.cursor_end, top_c_q == $past(top_c_q) + C_ONE)
	`BTC_ASSERT_NEXT(a_push_deepens, clk, arst_n, push, depth_q == $past(depth_q) + D_ONE)
	`BTC_ASSERT_IMP(a_clear_no_visit, clk, arst_n, cmd.op == btc_pkg::OP_CLEAR, !visit && !low_we)

endmodule

### rtl/btc_ctrl.sv
// Controller: sequences clearing, edge loads, the bridge walk and set lookups
`include "bridge_tree_connectivity_assert.svh"
module btc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  btc_pkg::mode_t mode,
	input  btc_pkg::stat_t stat,
	output btc_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_CLR   = 17'h00002,
		S_ROOT  = 17'h00004,
		S_RTEST = 17'h00008,
		S_STEP  = 17'h00010,
		S_EDGE  = 17'h00020,
		S_NB    = 17'h00040,
		S_POP   = 17'h00080,
		S_POPW  = 17'h00100,
		S_POPJ  = 17'h00200,
		S_FRD   = 17'h00400,
		S_FCMP  = 17'h00800,
		S_FEND  = 17'h01000,
		S_RK1   = 17'h02000,
		S_RK2   = 17'h04000,
		S_RK3   = 17'h08000,
		S_DONE  = 17'h10000
	} state_t;

	state_t         state_q, state_d;
	logic           boot_q;
	btc_pkg::mode_t mode_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = btc_pkg::OP_IDLE;
		cmd.query = (mode_q == btc_pkg::MODE_QUERY);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = btc_pkg::OP_ACCEPT;
					case (mode)
						btc_pkg::MODE_NEW:     state_d = S_CLR;
						btc_pkg::MODE_ADD:     state_d = S_DONE;
						btc_pkg::MODE_ANALYZE: state_d = S_CLR;
						default:               state_d = stat.in_range ? S_FRD : S_DONE;
					endcase
				end
			end
			S_CLR: begin
				cmd.op = btc_pkg::OP_CLEAR;
				if (stat.clr_last) begin
					if (boot_q) begin
						state_d = S_IDLE;
					end else begin
						state_d = (mode_q == btc_pkg::MODE_ANALYZE) ? S_ROOT : S_DONE;
					end
				end
			end
			S_ROOT: begin
				cmd.op  = btc_pkg::OP_ROOT;
				state_d = stat.root_end ? S_DONE : S_RTEST;
			end
			S_RTEST: begin
				cmd.op  = btc_pkg::OP_RTEST;
				state_d = stat.root_visited ? S_ROOT : S_STEP;
			end
			S_STEP: begin
				cmd.op  = btc_pkg::OP_STEP;
				state_d = stat.cursor_end ? S_POP : S_EDGE;
			end
			S_EDGE: begin
				cmd.op  = btc_pkg::OP_EDGE;
				state_d = stat.edge_hit ? S_NB : S_STEP;
			end
			S_NB: begin
				cmd.op  = btc_pkg::OP_NB;
				state_d = S_STEP;
			end
			S_POP: begin
				cmd.op  = btc_pkg::OP_POP;
				state_d = stat.depth_one ? S_ROOT : S_POPW;
			end
			S_POPW: begin
				cmd.op  = btc_pkg::OP_POPW;
				state_d = S_POPJ;
			end
			S_POPJ: begin
				cmd.op  = btc_pkg::OP_POPJ;
				state_d = stat.join_need ? S_FRD : S_STEP;
			end
			S_FRD: begin
				cmd.op  = btc_pkg::OP_FRD;
				state_d = S_FCMP;
			end
			S_FCMP: begin
				cmd.op  = btc_pkg::OP_FCMP;
				state_d = (stat.find_hit && stat.find_phase) ? S_FEND : S_FRD;
			end
			S_FEND: begin
				cmd.op = btc_pkg::OP_FEND;
				if (mode_q == btc_pkg::MODE_QUERY) begin
					state_d = S_DONE;
				end else begin
					state_d = stat.roots_equal ? S_STEP : S_RK1;
				end
			end
			S_RK1: begin
				cmd.op  = btc_pkg::OP_RK1;
				state_d = S_RK2;
			end
			S_RK2: begin
				cmd.op  = btc_pkg::OP_RK2;
				state_d = S_RK3;
			end
			S_RK3: begin
				cmd.op  = btc_pkg::OP_RK3;
				state_d = S_STEP;
			end
			S_DONE: begin
				cmd.op  = btc_pkg::OP_DONE;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// the clearing pass also runs straight out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			boot_q  <= 1'b1;
			mode_q  <= btc_pkg::MODE_NEW;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR && stat.clr_last) begin
				boot_q <= 1'b0;
			end
			if (cmd.op == btc_pkg::OP_ACCEPT) begin
				mode_q <= mode;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	`BTC_ASSERT_NEXT(a_done_then_idle, clk, arst_n, state_q == S_DONE, state_q == S_IDLE)
	`BTC_ASSERT_NEXT(a_add_one_beat, clk, arst_n, state_q == S_IDLE && start && mode == btc_pkg::MODE_ADD, state_q == S_DONE)

endmodule
